// ===== sv/spfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_pkg
// Shared types, frame layout constants and CRC helpers for the sample
// packet framer.
// ----------------------------------------------------------------------------
package spfc_pkg;

    // Frame layout
    localparam int FRAME_LEN = 25;
    localparam int CRC_SPAN  = 22;
    localparam int IDX_W     = 5;

    localparam logic [7:0] SYNC_A    = 8'hAA;
    localparam logic [7:0] SYNC_B    = 8'h55;
    localparam logic [7:0] TAIL_BYTE = 8'h00;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [IDX_W-1:0] POS_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_CRC_LO = IDX_W'(CRC_SPAN);
    localparam logic [IDX_W-1:0] POS_CRC_HI = IDX_W'(CRC_SPAN + 1);
    localparam logic [IDX_W-1:0] POS_TAIL   = IDX_W'(FRAME_LEN - 1);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [63:0] timestamp_us;
        logic [15:0] sensor_word_0;
        logic [15:0] sensor_word_1;
        logic [15:0] sensor_word_2;
        logic [15:0] sensor_word_3;
        logic [15:0] sensor_word_4;
        logic [15:0] sensor_word_5;
    } t_sample;

    // Advance CRC-16/CCITT by one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input t_byte data);
        logic [15:0] acc;
        acc = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (acc[15]) begin
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[14:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // Pick one of the bytes covered by the CRC
    function automatic t_byte data_byte(input t_sample s, input logic [IDX_W-1:0] idx);
        t_byte bytes [CRC_SPAN];
        t_byte res;
        bytes[0]  = SYNC_A;
        bytes[1]  = SYNC_B;
        for (int i = 0; i < 8; i++) begin
            bytes[2 + i] = s.timestamp_us[8*i +: 8];
        end
        bytes[10] = s.sensor_word_0[15:8];
        bytes[11] = s.sensor_word_0[7:0];
        bytes[12] = s.sensor_word_1[15:8];
        bytes[13] = s.sensor_word_1[7:0];
        bytes[14] = s.sensor_word_2[15:8];
        bytes[15] = s.sensor_word_2[7:0];
        bytes[16] = s.sensor_word_3[15:8];
        bytes[17] = s.sensor_word_3[7:0];
        bytes[18] = s.sensor_word_4[15:8];
        bytes[19] = s.sensor_word_4[7:0];
        bytes[20] = s.sensor_word_5[15:8];
        bytes[21] = s.sensor_word_5[7:0];
        if (idx < POS_CRC_LO) begin
            res = bytes[idx];
        end else begin
            res = TAIL_BYTE;
        end
        return res;
    endfunction

endpackage

// ===== sv/spfc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_if
// Valid/ready channels of the framer: the sample channel and the byte
// channel.
// ----------------------------------------------------------------------------
interface spfc_sample_if;
    logic        valid;
    logic        ready;
    logic [63:0] timestamp_us;
    logic [15:0] sensor_word_0;
    logic [15:0] sensor_word_1;
    logic [15:0] sensor_word_2;
    logic [15:0] sensor_word_3;
    logic [15:0] sensor_word_4;
    logic [15:0] sensor_word_5;

    modport source (
        output valid, timestamp_us, sensor_word_0, sensor_word_1, sensor_word_2,
               sensor_word_3, sensor_word_4, sensor_word_5,
        input  ready
    );
    modport sink (
        input  valid, timestamp_us, sensor_word_0, sensor_word_1, sensor_word_2,
               sensor_word_3, sensor_word_4, sensor_word_5,
        output ready
    );
endinterface

interface spfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== sv/spfc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_queue
// Front end: accepts sample words and holds them in a short queue until
// the serializer takes them.
// ----------------------------------------------------------------------------
module spfc_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spfc_sample_if.sink   i_sample,
    spfc_sample_if.source o_sample
);
    import spfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sample            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;
    t_sample            w_in;
    t_sample            w_out;

    // Pack the incoming word
    always_comb begin
        w_in.timestamp_us  = i_sample.timestamp_us;
        w_in.sensor_word_0 = i_sample.sensor_word_0;
        w_in.sensor_word_1 = i_sample.sensor_word_1;
        w_in.sensor_word_2 = i_sample.sensor_word_2;
        w_in.sensor_word_3 = i_sample.sensor_word_3;
        w_in.sensor_word_4 = i_sample.sensor_word_4;
        w_in.sensor_word_5 = i_sample.sensor_word_5;
    end

    assign i_sample.ready = (r_count != CNT_W'(DEPTH));
    assign o_sample.valid = (r_count != '0);
    assign w_push = i_sample.valid && i_sample.ready;
    assign w_pop  = o_sample.valid && o_sample.ready;

    // Present the oldest word
    assign w_out = r_mem[r_rd_ptr];
    assign o_sample.timestamp_us  = w_out.timestamp_us;
    assign o_sample.sensor_word_0 = w_out.sensor_word_0;
    assign o_sample.sensor_word_1 = w_out.sensor_word_1;
    assign o_sample.sensor_word_2 = w_out.sensor_word_2;
    assign o_sample.sensor_word_3 = w_out.sensor_word_3;
    assign o_sample.sensor_word_4 = w_out.sensor_word_4;
    assign o_sample.sensor_word_5 = w_out.sensor_word_5;

    // Store payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_in;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/spfc_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_serializer
// Back end: walks one sample through the 25 frame positions, folds each
// data byte into the running CRC and drives the registered byte output.
// ----------------------------------------------------------------------------
module spfc_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spfc_sample_if.sink i_sample,
    spfc_byte_if.source o_frame
);
    import spfc_pkg::*;

    t_sample            r_sample;
    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [15:0]        r_crc;
    logic               r_out_valid;
    t_byte              r_out_byte;
    logic               r_out_last;

    logic               w_advance;
    logic               w_emit;
    logic               w_load;
    t_byte              w_byte;
    t_sample            w_in;

    always_comb begin
        w_in.timestamp_us  = i_sample.timestamp_us;
        w_in.sensor_word_0 = i_sample.sensor_word_0;
        w_in.sensor_word_1 = i_sample.sensor_word_1;
        w_in.sensor_word_2 = i_sample.sensor_word_2;
        w_in.sensor_word_3 = i_sample.sensor_word_3;
        w_in.sensor_word_4 = i_sample.sensor_word_4;
        w_in.sensor_word_5 = i_sample.sensor_word_5;
    end

    // Output register is free when empty or being drained
    assign w_advance = !r_out_valid || o_frame.ready;
    assign w_emit    = w_advance && r_busy;
    // Take the next sample when idle or on the tail byte of the current one
    assign i_sample.ready = w_advance && (!r_busy || (r_idx == POS_TAIL));
    assign w_load    = i_sample.valid && i_sample.ready;

    // Select the byte for the current position
    always_comb begin
        if (r_idx < POS_CRC_LO) begin
            w_byte = data_byte(r_sample, r_idx);
        end else if (r_idx == POS_CRC_LO) begin
            w_byte = r_crc[7:0];
        end else if (r_idx == POS_CRC_HI) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = TAIL_BYTE;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sample <= w_in;
        end
        if (w_load) begin
            r_crc <= CRC_INIT;
        end else if (w_emit && (r_idx < POS_CRC_LO)) begin
            r_crc <= crc_byte(r_crc, w_byte);
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= (r_idx == POS_TAIL);
        end
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= POS_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= POS_FIRST;
            end else if (w_emit) begin
                if (r_idx == POS_TAIL) begin
                    r_busy <= 1'b0;
                    r_idx  <= POS_FIRST;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    assign o_frame.valid     = r_out_valid;
    assign o_frame.out_byte  = r_out_byte;
    assign o_frame.last_byte = r_out_last;

endmodule

// ===== sv/sample_packet_framer_crc16_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_packet_framer_crc16_core
// Frames one sensor sample into a 25-byte packet with a CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample takes one word per valid/ready handshake: a 64-bit timestamp and
//   six 16-bit sensor words. o_frame returns 25 bytes per sample: sync bytes
//   AA 55, the timestamp LSB first, the sensor words high byte first, the CRC
//   over the first 22 bytes low byte first, and a trailing zero flagged with
//   last_byte.
//   A sample accepted into an empty block passes through the queue and the
//   serializer's sample register before its first byte is registered on o_frame.
//   Throughput: one byte per cycle while o_frame does not stall; the
//   serializer loads the next sample on the tail byte, so frames can go out back to back.
//   A queue of QUEUE_DEPTH samples sits in front of the serializer, so
//   samples are taken while a frame is still going out.
//   When o_frame stalls, the held byte stays put and the serializer and then
//   the queue fill; i_sample.ready drops once the queue is full.
//   Reset empties the queue and drops any frame in flight.
// ----------------------------------------------------------------------------
module sample_packet_framer_crc16_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spfc_sample_if.sink   i_sample,
    spfc_byte_if.source   o_frame
);

    spfc_sample_if w_queued ();

    // Accept and hold samples
    spfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .o_sample (w_queued.source)
    );

    // Serialize frames
    spfc_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (w_queued.sink),
        .o_frame  (o_frame)
    );

endmodule

// ===== sv/spfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfc_checker
// Port-level checks on the framed byte stream.
// ----------------------------------------------------------------------------
module spfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_last_byte
);
    import spfc_pkg::*;

    logic             w_accept;
    logic [IDX_W-1:0] r_pos;

    assign w_accept = i_valid && i_ready;

    // Track the position of the next word in its frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
        end else if (w_accept) begin
            r_pos <= i_last_byte ? POS_FIRST : r_pos + 1'b1;
        end
    end

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_out_byte) && $stable(i_last_byte)))
        else $error("stalled output word changed");

    // Open every frame with the sync byte
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_pos == POS_FIRST)) |-> (i_out_byte == SYNC_A))
        else $error("frame does not start with sync byte");

    // Flag last exactly on the 25th word
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (i_last_byte == (r_pos == POS_TAIL)))
        else $error("last flag out of place");

    // Close every frame with the tail byte
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_byte) |-> (i_out_byte == TAIL_BYTE))
        else $error("tail byte is not zero");

    // Drop output after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

endmodule

bind sample_packet_framer_crc16_core spfc_checker u_spfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_frame.valid),
    .i_ready     (o_frame.ready),
    .i_out_byte  (o_frame.out_byte),
    .i_last_byte (o_frame.last_byte)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sample packet framer. Samples go in through a
// queue-fed driver and every framed byte is compared against a locally built
// frame: sync bytes, timestamp LSB first, sensor words high byte first, a
// CRC-16/CCITT-FALSE over the first 22 bytes, and the flagged zero tail.
// Both channels idle at random in bursts in two of the random phases, with a quiet stretch at the end.
// ----------------------------------------------------------------------------
module tb_top;

    import spfc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        t_byte data;
        logic  last;
        int    pos;
        int    sample_no;
    } t_frame_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spfc_sample_if sample_ch ();
    spfc_byte_if   frame_ch ();

    sample_packet_framer_crc16_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_frame  (frame_ch)
    );

    // Stimulus and expectation stores
    t_sample     samples_to_send [$];
    t_frame_byte frame_bytes_due [$];
    t_sample     sample_on_bus;
    t_frame_byte want_byte;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int src_gap       = 0;
    int sink_gap      = 0;

    int samples_accepted = 0;
    int bytes_checked    = 0;
    int mismatch_count   = 0;
    int quiet_cycles     = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Build the 25-byte frame for one sample and queue it as expected bytes
    task automatic predict_frame(input t_sample s, input int sample_no);
        t_byte       frame [FRAME_LEN];
        logic [15:0] words [6];
        logic [15:0] crc;
        t_frame_byte fb;
        words[0] = s.sensor_word_0;
        words[1] = s.sensor_word_1;
        words[2] = s.sensor_word_2;
        words[3] = s.sensor_word_3;
        words[4] = s.sensor_word_4;
        words[5] = s.sensor_word_5;
        frame[0] = 8'hAA;
        frame[1] = 8'h55;
        for (int i = 0; i < 8; i++) begin
            frame[2 + i] = s.timestamp_us[8*i +: 8];
        end
        for (int w = 0; w < 6; w++) begin
            frame[10 + 2*w] = words[w][15:8];
            frame[11 + 2*w] = words[w][7:0];
        end
        // CRC-16/CCITT-FALSE, MSB first, no final xor
        crc = 16'hFFFF;
        for (int i = 0; i < 22; i++) begin
            crc ^= {frame[i], 8'h00};
            for (int b = 0; b < 8; b++) begin
                crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
            end
        end
        frame[22] = crc[7:0];
        frame[23] = crc[15:8];
        frame[24] = 8'h00;
        for (int i = 0; i < FRAME_LEN; i++) begin
            fb.data      = frame[i];
            fb.last      = (i == FRAME_LEN - 1);
            fb.pos       = i;
            fb.sample_no = sample_no;
            frame_bytes_due.push_back(fb);
        end
    endtask

    // Random sample, with each field now and then pinned to an edge value
    function automatic t_sample random_sample();
        t_sample     s;
        logic [15:0] w;
        s.timestamp_us = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: s.timestamp_us = '0;
            1: s.timestamp_us = '1;
            2: s.timestamp_us = 64'h0000_0000_FFFF_FFFF;
            default: ;
        endcase
        for (int i = 0; i < 6; i++) begin
            w = 16'($urandom_range(0, 16'hFFFF));
            case ($urandom_range(0, 9))
                0: w = 16'h0000;
                1: w = 16'hFFFF;
                2: w = 16'h8000;
                default: ;
            endcase
            case (i)
                0: s.sensor_word_0 = w;
                1: s.sensor_word_1 = w;
                2: s.sensor_word_2 = w;
                3: s.sensor_word_3 = w;
                4: s.sensor_word_4 = w;
                default: s.sensor_word_5 = w;
            endcase
        end
        return s;
    endfunction

    // Sample driver: hold the word until taken, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                predict_frame(sample_on_bus, samples_accepted);
                samples_accepted++;
            end
            if (!(sample_ch.valid && !sample_ch.ready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    sample_ch.valid <= 1'b0;
                end else if (samples_to_send.size() > 0) begin
                    sample_on_bus = samples_to_send.pop_front();
                    sample_ch.valid         <= 1'b1;
                    sample_ch.timestamp_us  <= sample_on_bus.timestamp_us;
                    sample_ch.sensor_word_0 <= sample_on_bus.sensor_word_0;
                    sample_ch.sensor_word_1 <= sample_on_bus.sensor_word_1;
                    sample_ch.sensor_word_2 <= sample_on_bus.sensor_word_2;
                    sample_ch.sensor_word_3 <= sample_on_bus.sensor_word_3;
                    sample_ch.sensor_word_4 <= sample_on_bus.sensor_word_4;
                    sample_ch.sensor_word_5 <= sample_on_bus.sensor_word_5;
                    if ($urandom_range(0, 99) < src_idle_pct) begin
                        src_gap = $urandom_range(1, 5);
                    end
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: check each accepted word, then pick the next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_ch.ready <= 1'b0;
        end else begin
            if (frame_ch.valid && frame_ch.ready) begin
                if (frame_bytes_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h last=%0b",
                                            frame_ch.out_byte, frame_ch.last_byte));
                end else begin
                    want_byte = frame_bytes_due.pop_front();
                    if (frame_ch.out_byte !== want_byte.data) begin
                        flag_mismatch($sformatf("sample %0d byte %0d: out_byte %02h, want %02h",
                                                want_byte.sample_no, want_byte.pos,
                                                frame_ch.out_byte, want_byte.data));
                    end
                    if (frame_ch.last_byte !== want_byte.last) begin
                        flag_mismatch($sformatf("sample %0d byte %0d: last_byte %0b, want %0b",
                                                want_byte.sample_no, want_byte.pos,
                                                frame_ch.last_byte, want_byte.last));
                    end
                    bytes_checked++;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                frame_ch.ready <= 1'b0;
            end else begin
                frame_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < sink_idle_pct) begin
                    sink_gap = $urandom_range(1, 5);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic on either channel
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles, %0d bytes still due",
                     quiet_cycles, frame_bytes_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_sample s;
        int      directed_count;

        // Known values on every input before the first edge
        i_rst_n                 = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.timestamp_us  = '0;
        sample_ch.sensor_word_0 = '0;
        sample_ch.sensor_word_1 = '0;
        sample_ch.sensor_word_2 = '0;
        sample_ch.sensor_word_3 = '0;
        sample_ch.sensor_word_4 = '0;
        sample_ch.sensor_word_5 = '0;
        frame_ch.ready          = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners, back to back
        s = '0;
        samples_to_send.push_back(s);
        s = '1;
        samples_to_send.push_back(s);
        s = {64'h0123_4567_89AB_CDEF, 16'h0102, 16'h0304, 16'h0506,
             16'h0708, 16'h090A, 16'h0B0C};
        samples_to_send.push_back(s);
        s = {64'h8000_0000_0000_0001, 16'h8000, 16'h0001, 16'h8000,
             16'h0001, 16'h8000, 16'h0001};
        samples_to_send.push_back(s);
        s = {64'hAAAA_AAAA_AAAA_AAAA, {6{16'hAAAA}}};
        samples_to_send.push_back(s);
        s = {64'h5555_5555_5555_5555, {6{16'h5555}}};
        samples_to_send.push_back(s);
        s = {64'h0000_0000_FFFF_FFFF, 16'h00FF, 16'hFF00, 16'h00FF,
             16'hFF00, 16'h00FF, 16'hFF00};
        samples_to_send.push_back(s);
        s = {64'hFFFF_FFFF_0000_0000, 16'hFF00, 16'h00FF, 16'hFF00,
             16'h00FF, 16'hFF00, 16'h00FF};
        samples_to_send.push_back(s);
        // Walk a full byte through the timestamp
        for (int k = 0; k < 8; k++) begin
            s = '0;
            s.timestamp_us = 64'hFF << (8*k);
            samples_to_send.push_back(s);
        end
        // Light up one sensor word at a time
        for (int k = 0; k < 6; k++) begin
            s = '0;
            s[16*(5-k) +: 16] = 16'hFFFF;
            samples_to_send.push_back(s);
        end
        directed_count = samples_to_send.size();
        while (samples_to_send.size() != 0) @(posedge i_clk);

        // Random samples under moderate idling on both sides
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        for (int n = 0; n < 100; n++) begin
            samples_to_send.push_back(random_sample());
        end
        while (samples_to_send.size() != 0) @(posedge i_clk);

        // Heavy back-pressure so the queue inside fills and ready drops
        src_idle_pct  = 10;
        sink_idle_pct = 60;
        for (int n = 0; n < 100; n++) begin
            samples_to_send.push_back(random_sample());
        end
        while (samples_to_send.size() != 0) @(posedge i_clk);

        // Last stretch at full rate
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int n = 0; n < 60; n++) begin
            samples_to_send.push_back(random_sample());
        end
        while (samples_to_send.size() != 0 || sample_ch.valid) @(posedge i_clk);
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Framed %0d samples: %0d directed corners, the rest random under light,",
                 samples_accepted, directed_count);
        $display("heavy and no idling; %0d bytes checked, %0d mismatches",
                 bytes_checked, mismatch_count);
        if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
